// File: src/bucketed_range_assign_point_query_core_defines.svh
// assertion macros shared by the core
`ifndef BUCKETED_RANGE_ASSIGN_POINT_QUERY_CORE_DEFINES_SVH
`define BUCKETED_RANGE_ASSIGN_POINT_QUERY_CORE_DEFINES_SVH

// same-cycle implication, checked on clk, off during reset
`define BRA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define BRA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/bra_pkg.sv
package bra_pkg;

  localparam int IDX_W = 10;
  localparam int VAL_W = 31;
  localparam logic [VAL_W-1:0] VALUE_MAX = {VAL_W{1'b1}};

  localparam int DEF_ENTRIES     = 1024;
  localparam int DEF_BUCKET_SIZE = 32;
  localparam int DEF_BUCKETS     = 32;

  localparam logic OP_ASSIGN = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam int WALK_MODE_W = 3;
  localparam logic [WALK_MODE_W-1:0] WALK_CLEAR = 3'd0;
  localparam logic [WALK_MODE_W-1:0] WALK_FLUSH = 3'd1;
  localparam logic [WALK_MODE_W-1:0] WALK_LEFT  = 3'd2;
  localparam logic [WALK_MODE_W-1:0] WALK_RIGHT = 3'd3;
  localparam logic [WALK_MODE_W-1:0] WALK_TAG   = 3'd4;

  typedef struct packed {
    logic                   load;
    logic                   div_start;
    logic                   sel_bt;
    logic                   tag_rd;
    logic                   walk_load;
    logic [WALK_MODE_W-1:0] walk_mode;
    logic                   walk_step;
    logic                   clr_pend;
    logic                   rd_elem;
    logic                   out_load;
  } bra_cmd_t;

  typedef struct packed {
    logic div_done;
    logic walk_done;
    logic pend_hit;
    logic is_query;
    logic range_ok;
    logic same_bucket;
    logic out_free;
  } bra_sts_t;

endpackage

// File: src/bucketed_range_assign_point_query_core.sv
// channel | ports                                              | transfer when
// in      | in_opcode in_start_index in_end_index in_new_value | in_valid && !in_stall
// out     | out_read_value                                     | out_valid && !out_stall
//
// after reset the element store is filled one entry a cycle, in_stall high
// a query holds in_stall through the one-write-a-cycle flush of its bucket and until the
// result register is free
// an assign holds in_stall through at most
// two flushes, two partial bucket walks and one tag write per middle bucket
// one item at a time; a held result does not block the next item, only the next query result
module bucketed_range_assign_point_query_core
  import bra_pkg::*;
#(
  parameter int ENTRIES     = DEF_ENTRIES,
  parameter int BUCKET_SIZE = DEF_BUCKET_SIZE,
  parameter int BUCKETS     = DEF_BUCKETS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_opcode,
  input  logic [IDX_W-1:0] in_start_index,
  input  logic [IDX_W-1:0] in_end_index,
  input  logic [VAL_W-1:0] in_new_value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [VAL_W-1:0] out_read_value
);

  bra_cmd_t cmd;
  bra_sts_t sts;

  bra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bra_dp #(
    .ENTRIES     (ENTRIES),
    .BUCKET_SIZE (BUCKET_SIZE),
    .BUCKETS     (BUCKETS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_opcode      (in_opcode),
    .in_start_index (in_start_index),
    .in_end_index   (in_end_index),
    .in_new_value   (in_new_value),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_read_value (out_read_value)
  );

endmodule

// File: src/bra_div.sv
module bra_div
  import bra_pkg::*;
#(
  parameter int IW          = 10,
  parameter int BUCKET_SIZE = DEF_BUCKET_SIZE
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [IW-1:0] dividend,
  output logic          busy,
  output logic [IW-1:0] quotient
);

  localparam int SH = IW + $clog2(BUCKET_SIZE);
  localparam int MW = IW + 1;
  localparam int PW = IW + MW;
  localparam logic [MW-1:0] RECIP =
    MW'(((longint'(1) <<< SH) + longint'(BUCKET_SIZE) - longint'(1)) / longint'(BUCKET_SIZE));

  logic [PW-1:0] prod_r;
  logic [IW-1:0] q_r;
  logic          busy_r;

  // quotient by reciprocal multiplication, product registered first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= PW'(dividend) * PW'(RECIP);
    end
    if (busy_r) begin
      q_r <= IW'(prod_r >> SH);
    end
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule

// File: src/bra_dp.sv
`include "bucketed_range_assign_point_query_core_defines.svh"

module bra_dp
  import bra_pkg::*;
#(
  parameter int ENTRIES     = DEF_ENTRIES,
  parameter int BUCKET_SIZE = DEF_BUCKET_SIZE,
  parameter int BUCKETS     = DEF_BUCKETS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  bra_cmd_t         cmd,
  output bra_sts_t         sts,
  input  logic             in_opcode,
  input  logic [IDX_W-1:0] in_start_index,
  input  logic [IDX_W-1:0] in_end_index,
  input  logic [VAL_W-1:0] in_new_value,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [VAL_W-1:0] out_read_value
);

  localparam int IW = $clog2(ENTRIES);
  localparam int BW = (BUCKETS > 2) ? $clog2(BUCKETS) : 1;
  localparam int AW = $clog2(BUCKETS * BUCKET_SIZE + ENTRIES + 1);

  logic [VAL_W-1:0] elem_mem [ENTRIES];
  logic [VAL_W-1:0] tag_mem  [BUCKETS];
  logic [BUCKETS-1:0] pend_r;

  logic             op_r;
  logic [IW-1:0]    s_r;
  logic [IW-1:0]    t_r;
  logic [VAL_W-1:0] x_r;
  logic [VAL_W-1:0] tag_q_r;
  logic [VAL_W-1:0] rd_q_r;
  logic             out_valid_r;
  logic [VAL_W-1:0] out_value_r;

  logic [AW-1:0]          addr_r;
  logic [AW-1:0]          last_r;
  logic [WALK_MODE_W-1:0] mode_r;
  logic [AW-1:0]          addr_nxt;
  logic [AW-1:0]          last_nxt;

  logic [IW-1:0] s_clamp;
  logic [IW-1:0] t_clamp;
  logic          busy_s;
  logic          busy_t;
  logic [IW-1:0] q_s;
  logic [IW-1:0] q_t;
  logic [BW-1:0] bs;
  logic [BW-1:0] bt;
  logic [BW-1:0] b_sel;
  logic [AW-1:0] first_sel;
  logic [AW-1:0] end_sel;
  logic [AW-1:0] bound_sel;
  logic          walk_done;
  logic [VAL_W-1:0] wdata;

  // index saturation at the store size
  assign s_clamp = (32'(in_start_index) >= 32'(ENTRIES)) ? IW'(ENTRIES - 1)
                                                         : IW'(in_start_index);
  assign t_clamp = (32'(in_end_index) >= 32'(ENTRIES)) ? IW'(ENTRIES - 1)
                                                       : IW'(in_end_index);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_opcode;
      s_r  <= s_clamp;
      t_r  <= t_clamp;
      x_r  <= in_new_value;
    end
  end

  bra_div #(.IW(IW), .BUCKET_SIZE(BUCKET_SIZE)) u_div_s (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (s_r),
    .busy     (busy_s),
    .quotient (q_s)
  );

  bra_div #(.IW(IW), .BUCKET_SIZE(BUCKET_SIZE)) u_div_t (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (t_r),
    .busy     (busy_t),
    .quotient (q_t)
  );

  assign bs = (32'(q_s) >= 32'(BUCKETS)) ? BW'(BUCKETS - 1) : BW'(q_s);
  assign bt = (32'(q_t) >= 32'(BUCKETS)) ? BW'(BUCKETS - 1) : BW'(q_t);
  assign b_sel = cmd.sel_bt ? bt : bs;

  // bucket bounds, end limited to the store size
  assign first_sel = AW'(b_sel) * AW'(BUCKET_SIZE);
  assign bound_sel = first_sel + AW'(BUCKET_SIZE);
  assign end_sel   = (bound_sel > AW'(ENTRIES)) ? AW'(ENTRIES) : bound_sel;

  always_comb begin
    addr_nxt = '0;
    last_nxt = '0;
    unique case (cmd.walk_mode)
      WALK_CLEAR: begin
        addr_nxt = '0;
        last_nxt = AW'(ENTRIES - 1);
      end
      WALK_FLUSH: begin
        addr_nxt = first_sel;
        last_nxt = end_sel - AW'(1);
      end
      WALK_LEFT: begin
        addr_nxt = AW'(s_r);
        last_nxt = (bs == bt) ? AW'(t_r) : end_sel - AW'(1);
      end
      WALK_RIGHT: begin
        addr_nxt = first_sel;
        last_nxt = AW'(t_r);
      end
      WALK_TAG: begin
        addr_nxt = AW'(bs) + AW'(1);
        last_nxt = AW'(bt) - AW'(1);
      end
      default: begin
        addr_nxt = AW'(1);
        last_nxt = '0;
      end
    endcase
  end

  assign walk_done = (addr_r > last_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= WALK_CLEAR;
      addr_r <= AW'(1);
      last_r <= '0;
    end else if (cmd.walk_load) begin
      mode_r <= cmd.walk_mode;
      addr_r <= addr_nxt;
      last_r <= last_nxt;
    end else if (cmd.walk_step) begin
      addr_r <= addr_r + AW'(1);
    end
  end

  always_comb begin
    unique case (mode_r)
      WALK_CLEAR: wdata = VALUE_MAX;
      WALK_FLUSH: wdata = tag_q_r;
      default:    wdata = x_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_step && (mode_r != WALK_TAG)) begin
      elem_mem[addr_r[IW-1:0]] <= wdata;
    end
    if (cmd.rd_elem) begin
      rd_q_r <= elem_mem[s_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_step && (mode_r == WALK_TAG)) begin
      tag_mem[addr_r[BW-1:0]] <= x_r;
    end
    if (cmd.tag_rd) begin
      tag_q_r <= tag_mem[b_sel];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (cmd.clr_pend) begin
      pend_r[b_sel] <= 1'b0;
    end else if (cmd.walk_step && (mode_r == WALK_TAG)) begin
      pend_r[addr_r[BW-1:0]] <= 1'b1;
    end
  end

  // result register, parts the core from the output stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value_r <= rd_q_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;

  assign sts.div_done    = !busy_s && !busy_t;
  assign sts.walk_done   = walk_done;
  assign sts.pend_hit    = pend_r[b_sel];
  assign sts.is_query    = (op_r == OP_QUERY);
  assign sts.range_ok    = (s_r <= t_r);
  assign sts.same_bucket = (bs == bt);
  assign sts.out_free    = !out_valid_r || !out_stall;

  `BRA_ASSERT_IMP(a_elem_wr_in_range, cmd.walk_step && (mode_r != WALK_TAG), addr_r < AW'(ENTRIES), "element write beyond store")
  `BRA_ASSERT_IMP(a_step_live, cmd.walk_step, !walk_done, "walk step past its last address")
  `BRA_ASSERT_IMP(a_out_no_overwrite, cmd.out_load, !out_valid_r || !out_stall, "result register overwritten")
  `BRA_ASSERT_NEXT(a_flush_clears, cmd.clr_pend, !pend_r[$past(b_sel)], "pending bit kept after flush")

endmodule

// File: src/bra_ctrl.sv
module bra_ctrl
  import bra_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  bra_sts_t sts,
  output bra_cmd_t cmd
);

  localparam logic [3:0] ST_INIT   = 4'd0;
  localparam logic [3:0] ST_CLR    = 4'd1;
  localparam logic [3:0] ST_IDLE   = 4'd2;
  localparam logic [3:0] ST_DSTART = 4'd3;
  localparam logic [3:0] ST_DIV    = 4'd4;
  localparam logic [3:0] ST_FCHK   = 4'd5;
  localparam logic [3:0] ST_FLOAD  = 4'd6;
  localparam logic [3:0] ST_FWALK  = 4'd7;
  localparam logic [3:0] ST_LLOAD  = 4'd8;
  localparam logic [3:0] ST_LWALK  = 4'd9;
  localparam logic [3:0] ST_RLOAD  = 4'd10;
  localparam logic [3:0] ST_RWALK  = 4'd11;
  localparam logic [3:0] ST_TLOAD  = 4'd12;
  localparam logic [3:0] ST_TWALK  = 4'd13;
  localparam logic [3:0] ST_QRD    = 4'd14;
  localparam logic [3:0] ST_QOUT   = 4'd15;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       sel_r;
  logic       sel_nxt;
  logic [3:0] after_flush;

  // next step once a bucket has been flushed or found clean
  always_comb begin
    if (sts.is_query) begin
      after_flush = ST_QRD;
    end else if (!sel_r) begin
      after_flush = ST_FCHK;
    end else begin
      after_flush = ST_LLOAD;
    end
  end

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    cmd       = '0;
    unique case (state_r)
      ST_INIT: begin
        cmd.walk_load = 1'b1;
        cmd.walk_mode = WALK_CLEAR;
        state_nxt     = ST_CLR;
      end
      ST_CLR: begin
        if (!sts.walk_done) begin
          cmd.walk_step = 1'b1;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DSTART;
        end
      end
      ST_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done) begin
          sel_nxt = 1'b0;
          if (!sts.is_query && !sts.range_ok) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_FCHK;
          end
        end
      end
      ST_FCHK: begin
        cmd.sel_bt = sel_r;
        if (sts.pend_hit) begin
          cmd.tag_rd = 1'b1;
          state_nxt  = ST_FLOAD;
        end else begin
          sel_nxt   = 1'b1;
          state_nxt = after_flush;
        end
      end
      ST_FLOAD: begin
        cmd.sel_bt    = sel_r;
        cmd.walk_load = 1'b1;
        cmd.walk_mode = WALK_FLUSH;
        cmd.clr_pend  = 1'b1;
        state_nxt     = ST_FWALK;
      end
      ST_FWALK: begin
        if (!sts.walk_done) begin
          cmd.walk_step = 1'b1;
        end else begin
          sel_nxt   = 1'b1;
          state_nxt = after_flush;
        end
      end
      ST_LLOAD: begin
        cmd.walk_load = 1'b1;
        cmd.walk_mode = WALK_LEFT;
        state_nxt     = ST_LWALK;
      end
      ST_LWALK: begin
        if (!sts.walk_done) begin
          cmd.walk_step = 1'b1;
        end else if (sts.same_bucket) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_RLOAD;
        end
      end
      ST_RLOAD: begin
        cmd.sel_bt    = 1'b1;
        cmd.walk_load = 1'b1;
        cmd.walk_mode = WALK_RIGHT;
        state_nxt     = ST_RWALK;
      end
      ST_RWALK: begin
        if (!sts.walk_done) begin
          cmd.walk_step = 1'b1;
        end else begin
          state_nxt = ST_TLOAD;
        end
      end
      ST_TLOAD: begin
        cmd.walk_load = 1'b1;
        cmd.walk_mode = WALK_TAG;
        state_nxt     = ST_TWALK;
      end
      ST_TWALK: begin
        if (!sts.walk_done) begin
          cmd.walk_step = 1'b1;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_QRD: begin
        cmd.rd_elem = 1'b1;
        state_nxt   = ST_QOUT;
      end
      ST_QOUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      sel_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top
  import bra_pkg::*;
();

  localparam int RANDOM_OPS     = 1250;
  localparam int CALM_TAIL      = 150;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int DRAIN_CYCLES   = 400;

  typedef struct {
    logic             op;
    logic [IDX_W-1:0] first_idx;
    logic [IDX_W-1:0] last_idx;
    logic [VAL_W-1:0] value;
  } range_op_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             in_opcode = OP_QUERY;
  logic [IDX_W-1:0] in_start_index = '0;
  logic [IDX_W-1:0] in_end_index = '0;
  logic [VAL_W-1:0] in_new_value = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [VAL_W-1:0] out_read_value;

  range_op_t        pending_ops[$];
  logic [VAL_W-1:0] expected_reads[$];
  logic [VAL_W-1:0] shadow_store[DEF_ENTRIES];
  range_op_t        next_op;
  logic [VAL_W-1:0] want_value;
  int               send_gap = 0;
  int               stall_left = 0;
  int               quiet_cycles = 0;
  int               error_count = 0;

  bucketed_range_assign_point_query_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_start_index (in_start_index),
    .in_end_index   (in_end_index),
    .in_new_value   (in_new_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_value (out_read_value)
  );

  always #10 clk = ~clk;

  task automatic push_op(input logic op, input int first_idx, input int last_idx,
                         input logic [VAL_W-1:0] value);
    range_op_t item;
    item.op = op;
    item.first_idx = IDX_W'(first_idx);
    item.last_idx = IDX_W'(last_idx);
    item.value = value;
    pending_ops.push_back(item);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      return '0;
    end else if (sel == 1) begin
      return VALUE_MAX;
    end
    return VAL_W'($urandom);
  endfunction

  // driver: on every accepted transfer updates the shadow array (assign) or queues the expected read (query)
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (in_opcode == OP_QUERY) begin
          expected_reads.push_back(shadow_store[in_start_index]);
        end else if (in_start_index <= in_end_index) begin
          for (int k = in_start_index; k <= in_end_index; k++) begin
            shadow_store[k] = in_new_value;
          end
        end
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_ops.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 9);
          in_valid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          next_op = pending_ops.pop_front();
          in_valid <= 1'b1;
          in_opcode <= next_op.op;
          in_start_index <= next_op.first_idx;
          in_end_index <= next_op.last_idx;
          in_new_value <= next_op.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reads.size() == 0) begin
          $error("read_value: unexpected transfer, expected none, actual %0h",
                 out_read_value);
          error_count++;
        end else begin
          want_value = expected_reads.pop_front();
          if (out_read_value !== want_value) begin
            $error("read_value: expected %0h, actual %0h", want_value, out_read_value);
            error_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (pending_ops.size() > CALM_TAIL && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(0, 9);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    int sel;
    int first_idx;
    int last_idx;
    int span;

    foreach (shadow_store[k]) begin
      shadow_store[k] = VALUE_MAX;
    end

    // reset contents, whole-array assign, empty range
    push_op(OP_QUERY, 0, $urandom, VAL_W'($urandom));
    push_op(OP_QUERY, 1023, $urandom, VAL_W'($urandom));
    push_op(OP_ASSIGN, 0, 1023, '0);
    push_op(OP_QUERY, 0, $urandom, VAL_W'($urandom));
    push_op(OP_QUERY, 1023, $urandom, VAL_W'($urandom));
    push_op(OP_ASSIGN, 40, 20, VALUE_MAX);
    push_op(OP_QUERY, 30, $urandom, VAL_W'($urandom));
    // range inside one bucket
    push_op(OP_ASSIGN, 33, 40, VALUE_MAX);
    push_op(OP_QUERY, 32, $urandom, VAL_W'($urandom));
    push_op(OP_QUERY, 33, $urandom, VAL_W'($urandom));
    push_op(OP_QUERY, 40, $urandom, VAL_W'($urandom));
    // partial ends with tagged middle buckets
    push_op(OP_ASSIGN, 10, 700, 31'h2AAAAAAA);
    push_op(OP_QUERY, 9, $urandom, VAL_W'($urandom));
    push_op(OP_QUERY, 31, $urandom, VAL_W'($urandom));
    push_op(OP_QUERY, 32, $urandom, VAL_W'($urandom));
    push_op(OP_QUERY, 701, $urandom, VAL_W'($urandom));
    // write into a tagged bucket forces its flush
    push_op(OP_ASSIGN, 300, 310, 31'h55555555);
    push_op(OP_QUERY, 299, $urandom, VAL_W'($urandom));
    push_op(OP_QUERY, 305, $urandom, VAL_W'($urandom));
    push_op(OP_QUERY, 311, $urandom, VAL_W'($urandom));
    push_op(OP_ASSIGN, 1023, 1023, 31'd1);
    push_op(OP_QUERY, 1023, $urandom, VAL_W'($urandom));
    push_op(OP_ASSIGN, 64, 95, 31'h12345678);
    push_op(OP_QUERY, 95, $urandom, VAL_W'($urandom));
    push_op(OP_QUERY, 96, $urandom, VAL_W'($urandom));

    for (int n = 0; n < RANDOM_OPS; n++) begin
      sel = $urandom_range(0, 99);
      first_idx = $urandom_range(0, 1023);
      if (sel < 45) begin
        if ($urandom_range(0, 3) == 0) begin
          first_idx = $urandom_range(0, 31) * 32 + ($urandom_range(0, 1) ? 31 : 0);
        end
        push_op(OP_QUERY, first_idx, $urandom, VAL_W'($urandom));
      end else if (sel < 50) begin
        first_idx = $urandom_range(1, 1023);
        push_op(OP_ASSIGN, first_idx, $urandom_range(0, first_idx - 1), pick_value());
      end else begin
        case ($urandom_range(0, 3))
          0: span = $urandom_range(0, 31);
          1: span = $urandom_range(0, 200);
          2: span = $urandom_range(0, 1023);
          default: begin
            first_idx = $urandom_range(0, 31) * 32 + ($urandom_range(0, 1) ? 31 : 0);
            span = $urandom_range(0, 31) * 32 + ($urandom_range(0, 1) ? 31 : 0);
            span = (span >= first_idx) ? span - first_idx : 0;
          end
        endcase
        last_idx = (first_idx + span > 1023) ? 1023 : first_idx + span;
        push_op(OP_ASSIGN, first_idx, last_idx, pick_value());
      end
    end

    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() != 0 || in_valid !== 1'b0) @(posedge clk);
    while (expected_reads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && expected_reads.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// File: bucketed_range_assign_point_query_core.f
+incdir+src
src/bra_pkg.sv
src/bra_div.sv
src/bra_dp.sv
src/bra_ctrl.sv
src/bucketed_range_assign_point_query_core.sv
test/tb_top.sv
